### hdl/slot_table_allocator_defines.svh
// ---------------------------------------------------------------------------
// Slot table allocator assertion macros
// Shared wrappers for the concurrent checks of the slot table allocator.
// ---------------------------------------------------------------------------
`ifndef SLOT_TABLE_ALLOCATOR_DEFINES_SVH
`define SLOT_TABLE_ALLOCATOR_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define STA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slot table allocator check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define STA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slot table allocator check failed");

`endif

### hdl/sta_pkg.sv
// ---------------------------------------------------------------------------
// Slot table allocator package
// Sizes, operation codes, controller states and transaction types.
// ---------------------------------------------------------------------------
package sta_pkg;

  localparam int DEPTH      = 64;
  localparam int ITEM_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int OP_W       = 3;

  typedef enum logic [OP_W-1:0] {
    OP_PUT    = 3'd0,
    OP_GET    = 3'd1,
    OP_SET    = 3'd2,
    OP_REMOVE = 3'd3,
    OP_CLEAR  = 3'd4,
    OP_SWAP   = 3'd5
  } sta_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_EXEC,
    ST_READ,
    ST_SWAP_A,
    ST_SWAP_B,
    ST_SWAP_C,
    ST_MOVE
  } sta_state_t;

  typedef struct packed {
    logic [OP_W-1:0]       op;
    logic [IDX_W-1:0]      slot_index;
    logic [IDX_W-1:0]      other_index;
    logic [ITEM_WIDTH-1:0] item_data;
  } sta_req_t;

  typedef struct packed {
    logic                  ok;
    logic [IDX_W-1:0]      slot_out;
    logic [ITEM_WIDTH-1:0] read_data;
    logic [CNT_W-1:0]      used_count;
    logic                  is_full;
    logic                  is_empty;
  } sta_rsp_t;

endpackage

### hdl/slot_table_allocator.sv
// From acceptance to the result register: put runs the search counter over the slot marks,
// one slot mark examined per cycle; set, remove, clear, unknown codes, a get of a free slot
// and a swap that moves nothing finish in the execute state; get and a one-sided swap add a
// data memory read (READ, MOVE); a swap of two used slots runs SWAP_A, SWAP_B and SWAP_C.
// One transaction at a time; the next is accepted once the result has been taken.
// Reset (synchronous, active low) frees every slot, zeroes the count, sets capacity to 64.
// ---------------------------------------------------------------------------
// Slot table allocator
// Table of slots with used marks, data memory and live count; put searches
// for a free slot, and get, set, remove, clear and swap address slots.
// ---------------------------------------------------------------------------
`include "slot_table_allocator_defines.svh"

module slot_table_allocator (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sta_pkg::sta_req_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output sta_pkg::sta_rsp_t out_data,
  input  logic              cfg_wr_en,
  input  logic [sta_pkg::CNT_W-1:0] cfg_wr_data
);
  import sta_pkg::*;

  sta_state_t            state_r, state_nxt;
  logic [CNT_W-1:0]      cfg_r;
  logic [DEPTH-1:0]      used_r, used_nxt;
  logic [CNT_W-1:0]      live_r, live_nxt;
  logic [OP_W-1:0]       op_r;
  logic [IDX_W-1:0]      si_r, sj_r;
  logic [ITEM_WIDTH-1:0] item_r, tmp_r, tmp_nxt;
  logic [IDX_W-1:0]      capm1_r, capm1_nxt;
  logic [IDX_W-1:0]      k_r, k_nxt;
  logic [IDX_W-1:0]      step_r, step_nxt;
  logic                  out_valid_r, out_valid_nxt;
  sta_rsp_t              out_data_r, out_data_nxt;

  logic [ITEM_WIDTH-1:0] mem [DEPTH];
  logic [ITEM_WIDTH-1:0] mem_rd_r;
  logic [IDX_W-1:0]      mem_raddr, mem_waddr;
  logic [ITEM_WIDTH-1:0] mem_wdata;
  logic                  mem_we;

  logic                  accept;
  logic [CNT_W-1:0]      cap_full;
  logic                  vi, vj, fin, fin_ok;
  logic [IDX_W-1:0]      fin_slot, src_idx, dst_idx;
  logic [ITEM_WIDTH-1:0] fin_rd;

  assign in_stall  = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign vi      = si_r <= capm1_r;
  assign vj      = sj_r <= capm1_r;
  assign src_idx = used_r[si_r] ? si_r : sj_r;
  assign dst_idx = used_r[si_r] ? sj_r : si_r;

  always_comb begin
    if (cfg_r == '0) begin
      cap_full = CNT_W'(1);
    end else if (cfg_r > CNT_W'(DEPTH)) begin
      cap_full = CNT_W'(DEPTH);
    end else begin
      cap_full = cfg_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    live_nxt      = live_r;
    tmp_nxt       = tmp_r;
    capm1_nxt     = capm1_r;
    k_nxt         = k_r;
    step_nxt      = step_r;
    mem_raddr     = si_r;
    mem_waddr     = si_r;
    mem_wdata     = item_r;
    mem_we        = 1'b0;
    fin           = 1'b0;
    fin_ok        = 1'b0;
    fin_slot      = si_r;
    fin_rd        = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          capm1_nxt = IDX_W'(cap_full - CNT_W'(1));
          step_nxt  = '0;
          if (live_r < cap_full) begin
            k_nxt = live_r[IDX_W-1:0];
          end else begin
            k_nxt = '0;
          end
          state_nxt = (in_data.op == OP_PUT) ? ST_SEARCH : ST_EXEC;
        end
      end
      ST_SEARCH: begin
        if (!used_r[k_r]) begin
          mem_we        = 1'b1;
          mem_waddr     = k_r;
          used_nxt[k_r] = 1'b1;
          live_nxt      = live_r + CNT_W'(1);
          fin           = 1'b1;
          fin_ok        = 1'b1;
          fin_slot      = k_r;
        end else if (step_r == capm1_r) begin
          fin      = 1'b1;
          fin_slot = '0;
        end else begin
          k_nxt    = (k_r == capm1_r) ? '0 : k_r + IDX_W'(1);
          step_nxt = step_r + IDX_W'(1);
        end
      end
      ST_EXEC: begin
        case (op_r)
          OP_GET: begin
            if (vi && used_r[si_r]) begin
              state_nxt = ST_READ;
            end else begin
              fin = 1'b1;
            end
          end
          OP_SET: begin
            fin = 1'b1;
            if (vi) begin
              mem_we         = 1'b1;
              used_nxt[si_r] = 1'b1;
              fin_ok         = 1'b1;
              if (!used_r[si_r]) begin
                live_nxt = live_r + CNT_W'(1);
              end
            end
          end
          OP_REMOVE: begin
            fin = 1'b1;
            if (vi && used_r[si_r]) begin
              used_nxt[si_r] = 1'b0;
              live_nxt       = live_r - CNT_W'(1);
              fin_ok         = 1'b1;
            end
          end
          OP_CLEAR: begin
            fin      = 1'b1;
            fin_ok   = 1'b1;
            used_nxt = '0;
            live_nxt = '0;
          end
          OP_SWAP: begin
            if (!(vi && vj)) begin
              fin = 1'b1;
            end else if ((si_r == sj_r) || (!used_r[si_r] && !used_r[sj_r])) begin
              fin    = 1'b1;
              fin_ok = 1'b1;
            end else if (used_r[si_r] && used_r[sj_r]) begin
              state_nxt = ST_SWAP_A;
            end else begin
              mem_raddr = src_idx;
              state_nxt = ST_MOVE;
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
      ST_READ: begin
        fin    = 1'b1;
        fin_ok = 1'b1;
        fin_rd = mem_rd_r;
      end
      ST_SWAP_A: begin
        tmp_nxt   = mem_rd_r;
        mem_raddr = sj_r;
        state_nxt = ST_SWAP_B;
      end
      ST_SWAP_B: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rd_r;
        state_nxt = ST_SWAP_C;
      end
      ST_SWAP_C: begin
        mem_we    = 1'b1;
        mem_waddr = sj_r;
        mem_wdata = tmp_r;
        fin       = 1'b1;
        fin_ok    = 1'b1;
      end
      ST_MOVE: begin
        mem_we            = 1'b1;
        mem_waddr         = dst_idx;
        mem_wdata         = mem_rd_r;
        used_nxt[src_idx] = 1'b0;
        used_nxt[dst_idx] = 1'b1;
        fin               = 1'b1;
        fin_ok            = 1'b1;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (fin) begin
      state_nxt = ST_IDLE;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (fin) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.ok         = fin_ok;
      out_data_nxt.slot_out   = fin_slot;
      out_data_nxt.read_data  = fin_rd;
      out_data_nxt.used_count = live_nxt;
      out_data_nxt.is_full    = live_nxt > {1'b0, capm1_r};
      out_data_nxt.is_empty   = live_nxt == '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cfg_r       <= CNT_W'(DEPTH);
      used_r      <= '0;
      live_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      live_r      <= live_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        cfg_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_data.op;
      si_r   <= in_data.slot_index;
      sj_r   <= in_data.other_index;
      item_r <= in_data.item_data;
    end
    tmp_r      <= tmp_nxt;
    capm1_r    <= capm1_nxt;
    k_r        <= k_nxt;
    step_r     <= step_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rd_r <= mem[mem_raddr];
  end

  `STA_ASSERT_NOW(a_busy_stalls, state_r != ST_IDLE, in_stall)
  `STA_ASSERT_NOW(a_busy_out_empty, state_r != ST_IDLE, !out_valid_r)
  `STA_ASSERT_NOW(a_count_matches_marks, 1'b1, live_r == CNT_W'($countones(used_r)))
  `STA_ASSERT_NEXT(a_fin_loads_result, fin, out_valid_r && state_r == ST_IDLE)

endmodule

### tb/sv/tb_slot_table_allocator.sv
// ---------------------------------------------------------------------------
// Slot table allocator testbench
// Drives put, get, set, remove, clear, swap and reserved operation codes
// through the valid/stall request channel, first from a directed stimulus
// list and then at random under several capacity settings and idle mixes.
// Every accepted transaction is run through an in-bench model of the slot
// table, and each result is compared field by field in arrival order.
// ---------------------------------------------------------------------------
module tb_slot_table_allocator;
  import sta_pkg::*;

  localparam int CLK_PERIOD       = 4;
  localparam int RESET_CYCLES     = 11;
  localparam int CYCLE_LIMIT      = 1_000_000;
  localparam int SETTLE_CYCLES    = 8;
  localparam int TAIL_CYCLES      = 80;
  localparam int LONG_HOLD        = 400;
  localparam int PHASES           = 3;
  localparam int BLOCKS_PER_PHASE = 6;
  localparam int ITEMS_PER_BLOCK  = 103;
  localparam int MAX_REPORTS      = 10;

  localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

  typedef struct {
    bit               is_cfg;
    logic [CNT_W-1:0] cap_value;
    sta_req_t         req;
    bit               typed;
    sta_rsp_t         rsp;
  } stim_row_t;

  logic             clk         = 1'b0;
  logic             rst_n       = 1'b0;
  logic             in_valid    = 1'b0;
  logic             in_stall;
  sta_req_t         in_data     = '0;
  logic             out_valid;
  logic             out_stall   = 1'b0;
  sta_rsp_t         out_data;
  logic             cfg_wr_en   = 1'b0;
  logic [CNT_W-1:0] cfg_wr_data = '0;

  bit                    slot_used [DEPTH];
  logic [ITEM_WIDTH-1:0] slot_word [DEPTH];
  int                    live_slots = 0;
  logic [CNT_W-1:0]      capacity_reg = 7'd64;

  sta_rsp_t  expected_rsp_q [$];
  stim_row_t stim_rows [$];
  bit        cur_typed = 1'b0;
  sta_rsp_t  cur_rsp   = '0;
  int        mismatches = 0;
  int        cycle_count = 0;
  int        snd_idle_pct = 36;
  int        rcv_idle_pct = 60;
  int        hold_requests = 0;
  int        hold_served = 0;
  int        hold_left = 0;

  slot_table_allocator u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic int effective_capacity();
    if (capacity_reg == 0) return 1;
    if (capacity_reg > DEPTH) return DEPTH;
    return capacity_reg;
  endfunction

  function automatic sta_rsp_t allocator_predict(sta_req_t req);
    sta_rsp_t              rsp;
    int                    cap;
    int                    k;
    int                    lim;
    int                    hit;
    bit                    found;
    bit                    vi;
    bit                    vj;
    logic [ITEM_WIDTH-1:0] held;
    cap = effective_capacity();
    vi = req.slot_index < cap;
    vj = req.other_index < cap;
    rsp = '0;
    rsp.slot_out = req.slot_index;
    case (req.op)
      OP_PUT: begin
        found = 1'b0;
        hit = 0;
        lim = (live_slots < cap) ? live_slots : cap;
        for (k = live_slots; k < cap && !found; k++) begin
          if (!slot_used[k]) begin
            found = 1'b1;
            hit = k;
          end
        end
        for (k = 0; k < lim && !found; k++) begin
          if (!slot_used[k]) begin
            found = 1'b1;
            hit = k;
          end
        end
        if (found) begin
          slot_word[hit] = req.item_data;
          slot_used[hit] = 1'b1;
          live_slots++;
          rsp.ok = 1'b1;
          rsp.slot_out = IDX_W'(hit);
        end else begin
          rsp.slot_out = '0;
        end
      end
      OP_GET: begin
        if (vi && slot_used[req.slot_index]) begin
          rsp.ok = 1'b1;
          rsp.read_data = slot_word[req.slot_index];
        end
      end
      OP_SET: begin
        if (vi) begin
          slot_word[req.slot_index] = req.item_data;
          if (!slot_used[req.slot_index]) begin
            slot_used[req.slot_index] = 1'b1;
            live_slots++;
          end
          rsp.ok = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (vi && slot_used[req.slot_index]) begin
          slot_used[req.slot_index] = 1'b0;
          live_slots--;
          rsp.ok = 1'b1;
        end
      end
      OP_CLEAR: begin
        for (k = 0; k < DEPTH; k++) slot_used[k] = 1'b0;
        live_slots = 0;
        rsp.ok = 1'b1;
      end
      OP_SWAP: begin
        if (vi && vj) begin
          rsp.ok = 1'b1;
          if (req.slot_index != req.other_index) begin
            if (slot_used[req.slot_index] && slot_used[req.other_index]) begin
              held = slot_word[req.slot_index];
              slot_word[req.slot_index] = slot_word[req.other_index];
              slot_word[req.other_index] = held;
            end else if (slot_used[req.slot_index]) begin
              slot_word[req.other_index] = slot_word[req.slot_index];
              slot_used[req.slot_index] = 1'b0;
              slot_used[req.other_index] = 1'b1;
            end else if (slot_used[req.other_index]) begin
              slot_word[req.slot_index] = slot_word[req.other_index];
              slot_used[req.other_index] = 1'b0;
              slot_used[req.slot_index] = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase
    rsp.used_count = CNT_W'(live_slots);
    rsp.is_full = live_slots >= cap;
    rsp.is_empty = live_slots == 0;
    return rsp;
  endfunction

  function automatic void check_result(sta_rsp_t got);
    sta_rsp_t want;
    if (expected_rsp_q.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("ERROR: unexpected result ok=%0d slot=%0d data=%h count=%0d full=%0d empty=%0d",
                 got.ok, got.slot_out, got.read_data, got.used_count, got.is_full,
                 got.is_empty);
      return;
    end
    want = expected_rsp_q.pop_front();
    if (got.ok !== want.ok || got.slot_out !== want.slot_out ||
        got.read_data !== want.read_data || got.used_count !== want.used_count ||
        got.is_full !== want.is_full || got.is_empty !== want.is_empty) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("ERROR: expected ok=%0d slot=%0d data=%h count=%0d full=%0d empty=%0d",
                 want.ok, want.slot_out, want.read_data, want.used_count, want.is_full,
                 want.is_empty);
        $display("       actual   ok=%0d slot=%0d data=%h count=%0d full=%0d empty=%0d",
                 got.ok, got.slot_out, got.read_data, got.used_count, got.is_full,
                 got.is_empty);
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_wr_en) capacity_reg = cfg_wr_data;
      if (in_valid && !in_stall) begin
        if (cur_typed) begin
          void'(allocator_predict(in_data));
          expected_rsp_q.push_back(cur_rsp);
        end else begin
          expected_rsp_q.push_back(allocator_predict(in_data));
        end
      end
      if (out_valid && !out_stall) check_result(out_data);
    end
  end

  always @(negedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL slot_table_allocator");
      $finish;
    end
  end

  function automatic sta_req_t make_req(logic [OP_W-1:0] op, int si, int sj,
                                        logic [ITEM_WIDTH-1:0] word);
    sta_req_t req;
    req.op = op;
    req.slot_index = IDX_W'(si);
    req.other_index = IDX_W'(sj);
    req.item_data = word;
    return req;
  endfunction

  function automatic void add_op(logic [OP_W-1:0] op, int si, int sj,
                                 logic [ITEM_WIDTH-1:0] word);
    stim_row_t row;
    row.is_cfg = 1'b0;
    row.cap_value = '0;
    row.req = make_req(op, si, sj, word);
    row.typed = 1'b0;
    row.rsp = '0;
    stim_rows.push_back(row);
  endfunction

  function automatic void add_checked(logic [OP_W-1:0] op, int si, int sj,
                                      logic [ITEM_WIDTH-1:0] word, bit ok, int slot,
                                      logic [ITEM_WIDTH-1:0] rd, int count, bit full,
                                      bit empty);
    stim_row_t row;
    row.is_cfg = 1'b0;
    row.cap_value = '0;
    row.req = make_req(op, si, sj, word);
    row.typed = 1'b1;
    row.rsp.ok = ok;
    row.rsp.slot_out = IDX_W'(slot);
    row.rsp.read_data = rd;
    row.rsp.used_count = CNT_W'(count);
    row.rsp.is_full = full;
    row.rsp.is_empty = empty;
    stim_rows.push_back(row);
  endfunction

  function automatic void add_cap(logic [CNT_W-1:0] value);
    stim_row_t row;
    row.is_cfg = 1'b1;
    row.cap_value = value;
    row.req = '0;
    row.typed = 1'b0;
    row.rsp = '0;
    stim_rows.push_back(row);
  endfunction

  function automatic logic [CNT_W-1:0] capacity_for_block(int n);
    case (n)
      0: return 7'd64;
      1: return 7'd1;
      2: return 7'd5;
      3: return 7'd127;
      4: return 7'd2;
      5: return 7'd64;
      6: return 7'd0;
      7: return 7'd8;
      8: return 7'd63;
      9: return 7'd3;
      10: return 7'd65;
      11: return 7'd16;
      12: return 7'd4;
      13: return 7'd64;
      14: return 7'd7;
      15: return 7'd1;
      16: return 7'd40;
      default: return CNT_W'($urandom_range(1, DEPTH));
    endcase
  endfunction

  function automatic logic [OP_W-1:0] pick_op(bit filling);
    int r;
    r = $urandom_range(0, 99);
    if (filling) begin
      if (r < 45) return OP_PUT;
      if (r < 63) return OP_GET;
      if (r < 73) return OP_SET;
      if (r < 83) return OP_REMOVE;
      if (r < 85) return OP_CLEAR;
      if (r < 96) return OP_SWAP;
    end else begin
      if (r < 25) return OP_PUT;
      if (r < 45) return OP_GET;
      if (r < 52) return OP_SET;
      if (r < 77) return OP_REMOVE;
      if (r < 80) return OP_CLEAR;
      if (r < 94) return OP_SWAP;
    end
    return r[0] ? OP_RSVD_7 : OP_RSVD_6;
  endfunction

  function automatic int pick_slot();
    int r;
    int k;
    int used_list [$];
    r = $urandom_range(0, 99);
    if (r < 15) return $urandom_range(0, DEPTH - 1);
    if (r < 60) begin
      for (k = 0; k < DEPTH; k++) begin
        if (slot_used[k]) used_list.push_back(k);
      end
      if (used_list.size() != 0) return used_list[$urandom_range(0, used_list.size() - 1)];
    end
    return $urandom_range(0, effective_capacity() - 1);
  endfunction

  function automatic logic [ITEM_WIDTH-1:0] pick_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    return $urandom;
  endfunction

  task automatic send_item(sta_req_t req, bit typed, sta_rsp_t rsp);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    cur_typed <= typed;
    cur_rsp <= rsp;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_random(bit filling);
    logic [OP_W-1:0] op;
    int              si;
    int              sj;
    op = pick_op(filling);
    si = pick_slot();
    sj = (op == OP_SWAP) ? pick_slot() : $urandom_range(0, DEPTH - 1);
    send_item(make_req(op, si, sj, pick_word()), 1'b0, '0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_rsp_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_capacity(logic [CNT_W-1:0] value);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    int ph;
    int blk;
    add_checked(OP_GET,    0,  0,  32'h0,          0, 0,  32'h0,          0, 0, 1);
    add_checked(OP_REMOVE, 63, 0,  32'h0,          0, 63, 32'h0,          0, 0, 1);
    add_checked(OP_SWAP,   0,  63, 32'h0,          1, 0,  32'h0,          0, 0, 1);
    add_checked(OP_PUT,    0,  0,  32'hFFFF_FFFF,  1, 0,  32'h0,          1, 0, 0);
    add_checked(OP_PUT,    0,  0,  32'h0,          1, 1,  32'h0,          2, 0, 0);
    add_checked(OP_GET,    0,  0,  32'h0,          1, 0,  32'hFFFF_FFFF,  2, 0, 0);
    add_checked(OP_SET,    63, 0,  32'hA5A5_5A5A,  1, 63, 32'h0,          3, 0, 0);
    add_op(OP_GET,  63, 0,  32'h0);
    add_op(OP_SWAP, 0,  63, 32'h0);
    add_op(OP_SWAP, 1,  40, 32'h0);
    add_op(OP_SWAP, 5,  5,  32'h0);
    add_checked(OP_RSVD_6, 63, 63, 32'hFFFF_FFFF,  0, 63, 32'h0,          3, 0, 0);
    add_checked(OP_RSVD_7, 0,  0,  32'h0,          0, 0,  32'h0,          3, 0, 0);
    add_op(OP_REMOVE, 40, 0, 32'h0);
    add_op(OP_SET,    63, 0, 32'h0000_0001);
    add_checked(OP_CLEAR,  0,  0,  32'h0,          1, 0,  32'h0,          0, 0, 1);
    add_cap(7'd0);
    add_checked(OP_PUT,    0,  0,  32'h1234_5678,  1, 0,  32'h0,          1, 1, 0);
    add_checked(OP_PUT,    0,  0,  32'h0,          0, 0,  32'h0,          1, 1, 0);
    add_checked(OP_GET,    1,  0,  32'h0,          0, 1,  32'h0,          1, 1, 0);
    add_checked(OP_SWAP,   0,  1,  32'h0,          0, 0,  32'h0,          1, 1, 0);
    add_cap(7'd127);
    add_op(OP_PUT, 0,  0, 32'hDEAD_BEEF);
    add_op(OP_SET, 63, 0, 32'h8000_0000);
    add_cap(7'd2);
    add_op(OP_PUT,    0,  0, 32'h0F0F_0F0F);
    add_op(OP_REMOVE, 63, 0, 32'h0);
    add_checked(OP_CLEAR,  0,  0,  32'h0,          1, 0,  32'h0,          0, 0, 1);

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (stim_rows[n]) begin
      if (stim_rows[n].is_cfg) write_capacity(stim_rows[n].cap_value);
      else send_item(stim_rows[n].req, stim_rows[n].typed, stim_rows[n].rsp);
    end

    for (ph = 0; ph < PHASES; ph++) begin
      snd_idle_pct = (ph == 0) ? 36 : (ph == 1) ? 60 : 0;
      rcv_idle_pct = (ph == 0) ? 60 : (ph == 1) ? 36 : 0;
      for (blk = 0; blk < BLOCKS_PER_PHASE; blk++) begin
        write_capacity(capacity_for_block(ph * BLOCKS_PER_PHASE + blk));
        if (ph == PHASES - 1 && blk == 0) hold_requests++;
        repeat (ITEMS_PER_BLOCK) send_random(blk[0] == 1'b0);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0 && expected_rsp_q.size() == 0) begin
      $display("PASS slot_table_allocator");
    end else begin
      $display("FAIL slot_table_allocator");
    end
    $finish;
  end

endmodule
